// ===== rtl/xtt_pkg.sv =====
package xtt_pkg;

    typedef enum logic [3:0] {
        MODE_SEEK   = 4'd0,
        MODE_LT     = 4'd1,
        MODE_TFIRST = 4'd2,
        MODE_TITLE  = 4'd3,
        MODE_GAP    = 4'd4,
        MODE_ANAME  = 4'd5,
        MODE_EQ     = 4'd6,
        MODE_VALUE  = 4'd7,
        MODE_SLASH  = 4'd8,
        MODE_SKIP   = 4'd9
    } mode_t;

    localparam logic [1:0] KIND_BEGIN  = 2'd0;
    localparam logic [1:0] KIND_END    = 2'd1;
    localparam logic [1:0] KIND_SINGLE = 2'd2;

    localparam logic [1:0] CLASS_NONE  = 2'd0;
    localparam logic [1:0] CLASS_TITLE = 2'd1;
    localparam logic [1:0] CLASS_ANAME = 2'd2;
    localparam logic [1:0] CLASS_VALUE = 2'd3;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_NO_TITLE = 3'd1;
    localparam logic [2:0] ERR_NO_EQ    = 3'd2;
    localparam logic [2:0] ERR_NO_QUOTE = 3'd3;
    localparam logic [2:0] ERR_DSLASH   = 3'd4;
    localparam logic [2:0] ERR_NO_CLOSE = 3'd5;

    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_USCORE = 8'h5F;

    typedef struct packed {
        mode_t      mode;
        logic [1:0] kind;
        logic       skip_in_quote;
        logic       escape_pending;
    } parse_state_t;

    typedef struct packed {
        logic [2:0] error_code;
        logic [1:0] tag_kind;
        logic       tag_done;
        logic       attr_has_value;
        logic       attr_done;
        logic [7:0] char_out;
        logic [1:0] char_class;
    } token_t;

endpackage

// ===== rtl/xml_tag_tokenizer.sv =====
// xml_tag_tokenizer: byte-stream tag tokeniser.
// Input channel s_*: one text byte per request in s_tdata.
// Result channel m_*: exactly one result per input byte, in order.
//   m_tuser holds the character class, m_tdata the payload character,
//   the attribute and tag flags, the tag kind and the error code.
// Path: an accepted byte lands in the input register, the parse step then
//   fills the result register, which drives m_tvalid.
// Throughput: one byte per cycle while the result is not stalled; the single
//   parse step between the input register and the result register sets this figure.
// Stall: when m_tready is low the result register holds; the input
//   register still takes one more byte, after which s_tready drops until
//   the result is taken. No byte is lost or repeated.
// Reset (aresetn low, synchronous): both registers empty, parser seeks
//   the next '<' with a begin tag kind and no quote or escape pending.
module xml_tag_tokenizer
    import xtt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] char_out, [8] attr_done, [9] attr_has_value,
                                   // [10] tag_done, [12:11] tag_kind, [15:13] error_code
    output logic [1:0]  m_tuser    // [1:0] char_class
);

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg;
    token_t       out_token_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    token_t       token_next;
    logic         advance;

    xtt_step u_step (
        .state_cur (state_reg),
        .data_byte (in_byte_reg),
        .state_nxt (state_next),
        .token     (token_next)
    );

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg             <= 1'b0;
            out_valid_reg            <= 1'b0;
            state_reg.mode           <= MODE_SEEK;
            state_reg.kind           <= KIND_BEGIN;
            state_reg.skip_in_quote  <= 1'b0;
            state_reg.escape_pending <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg) begin
                    state_reg <= state_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
        if (advance && in_valid_reg) begin
            out_token_reg <= token_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_token_reg.char_class;
    assign m_tdata  = {out_token_reg.error_code, out_token_reg.tag_kind,
                       out_token_reg.tag_done, out_token_reg.attr_has_value,
                       out_token_reg.attr_done, out_token_reg.char_out};

`ifndef SYNTHESIS
    a_err_no_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[15:13] != ERR_NONE) |-> !m_tdata[10])
        else $error("error reported together with a closed tag");

    a_value_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9] |-> m_tdata[8])
        else $error("attribute value flag without attribute completion");

    a_kind_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[10] |-> (m_tdata[12:11] == KIND_BEGIN))
        else $error("tag kind set without tag completion");

    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready && in_valid_reg)
        else $error("input stalled without a blocked result");
`endif

endmodule

// ===== rtl/xtt_step.sv =====
module xtt_step
    import xtt_pkg::*;
(
    input  parse_state_t state_cur,
    input  logic [7:0]   data_byte,
    output parse_state_t state_nxt,
    output token_t       token
);

    logic       is_name;
    logic       is_blank;
    logic       slash;
    logic       close;
    logic       fail;
    logic [2:0] fail_code;

    assign is_name = (data_byte >= 8'h61 && data_byte <= 8'h7A)
                  || (data_byte >= 8'h41 && data_byte <= 8'h5A)
                  || (data_byte >= 8'h30 && data_byte <= 8'h39)
                  || (data_byte == CH_USCORE);
    assign is_blank = (data_byte == CH_SPACE) || (data_byte == CH_NL);

    always_comb begin
        state_nxt = state_cur;
        token     = '0;
        slash     = 1'b0;
        close     = 1'b0;
        fail      = 1'b0;
        fail_code = ERR_NONE;

        case (state_cur.mode)
            MODE_LT, MODE_TFIRST: begin
                if (state_cur.mode == MODE_LT && data_byte == CH_SLASH) begin
                    state_nxt.kind = KIND_END;
                    state_nxt.mode = MODE_TFIRST;
                end else if (is_name) begin
                    token.char_class = CLASS_TITLE;
                    token.char_out   = data_byte;
                    state_nxt.mode   = MODE_TITLE;
                end else begin
                    fail      = 1'b1;
                    fail_code = ERR_NO_TITLE;
                end
            end
            MODE_TITLE: begin
                if (is_name) begin
                    token.char_class = CLASS_TITLE;
                    token.char_out   = data_byte;
                end else if (is_blank) begin
                    state_nxt.mode = MODE_GAP;
                end else if (data_byte == CH_SLASH) begin
                    slash = 1'b1;
                end else if (data_byte == CH_GT) begin
                    close = 1'b1;
                end else begin
                    fail      = 1'b1;
                    fail_code = ERR_NO_CLOSE;
                end
            end
            MODE_GAP: begin
                if (is_blank) begin
                    state_nxt.mode = MODE_GAP;
                end else if (is_name) begin
                    token.char_class = CLASS_ANAME;
                    token.char_out   = data_byte;
                    state_nxt.mode   = MODE_ANAME;
                end else if (data_byte == CH_SLASH) begin
                    slash = 1'b1;
                end else if (data_byte == CH_GT) begin
                    close = 1'b1;
                end else begin
                    fail      = 1'b1;
                    fail_code = ERR_NO_CLOSE;
                end
            end
            MODE_ANAME: begin
                if (is_name) begin
                    token.char_class = CLASS_ANAME;
                    token.char_out   = data_byte;
                end else if (is_blank) begin
                    token.attr_done = 1'b1;
                    state_nxt.mode  = MODE_GAP;
                end else if (data_byte == CH_SLASH) begin
                    token.attr_done = 1'b1;
                    slash           = 1'b1;
                end else if (data_byte == CH_GT) begin
                    token.attr_done = 1'b1;
                    close           = 1'b1;
                end else if (data_byte == CH_EQ) begin
                    state_nxt.mode = MODE_EQ;
                end else begin
                    fail      = 1'b1;
                    fail_code = ERR_NO_EQ;
                end
            end
            MODE_EQ: begin
                if (data_byte == CH_QUOTE) begin
                    state_nxt.mode           = MODE_VALUE;
                    state_nxt.escape_pending = 1'b0;
                end else begin
                    fail      = 1'b1;
                    fail_code = ERR_NO_QUOTE;
                end
            end
            MODE_VALUE: begin
                if (state_cur.escape_pending) begin
                    state_nxt.escape_pending = 1'b0;
                    token.char_class         = CLASS_VALUE;
                    token.char_out           = data_byte;
                end else if (data_byte == CH_BSLASH) begin
                    state_nxt.escape_pending = 1'b1;
                end else if (data_byte == CH_QUOTE) begin
                    token.attr_done      = 1'b1;
                    token.attr_has_value = 1'b1;
                    state_nxt.mode       = MODE_GAP;
                end else begin
                    token.char_class = CLASS_VALUE;
                    token.char_out   = data_byte;
                end
            end
            MODE_SLASH: begin
                if (data_byte == CH_GT) begin
                    close = 1'b1;
                end else begin
                    fail      = 1'b1;
                    fail_code = ERR_NO_CLOSE;
                end
            end
            MODE_SKIP: begin
                if (state_cur.skip_in_quote) begin
                    if (state_cur.escape_pending) begin
                        state_nxt.escape_pending = 1'b0;
                    end else if (data_byte == CH_BSLASH) begin
                        state_nxt.escape_pending = 1'b1;
                    end else if (data_byte == CH_QUOTE) begin
                        state_nxt.skip_in_quote = 1'b0;
                    end
                end else if (data_byte == CH_GT) begin
                    state_nxt.mode = MODE_SEEK;
                    state_nxt.kind = KIND_BEGIN;
                end else if (data_byte == CH_QUOTE) begin
                    state_nxt.skip_in_quote = 1'b1;
                end
            end
            default: begin
                if (data_byte == CH_LT) begin
                    state_nxt.mode           = MODE_LT;
                    state_nxt.kind           = KIND_BEGIN;
                    state_nxt.skip_in_quote  = 1'b0;
                    state_nxt.escape_pending = 1'b0;
                end else begin
                    state_nxt.mode = MODE_SEEK;
                end
            end
        endcase

        if (slash) begin
            if (state_cur.kind == KIND_END) begin
                fail      = 1'b1;
                fail_code = ERR_DSLASH;
            end else begin
                state_nxt.kind = KIND_SINGLE;
                state_nxt.mode = MODE_SLASH;
            end
        end

        if (close) begin
            token.tag_done = 1'b1;
            token.tag_kind = state_cur.kind;
            state_nxt.mode = MODE_SEEK;
            state_nxt.kind = KIND_BEGIN;
        end

        // drop the bad tag: skip up to the next unquoted close
        if (fail) begin
            token.error_code         = fail_code;
            state_nxt.escape_pending = 1'b0;
            if (data_byte == CH_GT) begin
                state_nxt.mode          = MODE_SEEK;
                state_nxt.kind          = KIND_BEGIN;
                state_nxt.skip_in_quote = 1'b0;
            end else begin
                state_nxt.mode          = MODE_SKIP;
                state_nxt.skip_in_quote = (data_byte == CH_QUOTE);
            end
        end
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import xtt_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] data_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // [7:0] char_out, [8] attr_done, [9] attr_has_value,
                                     // [10] tag_done, [12:11] tag_kind, [15:13] error_code
    logic [1:0]  m_tuser;            // [1:0] char_class

    xml_tag_tokenizer u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    // parser copy
    mode_t      pm = MODE_SEEK;
    logic [1:0] pk = KIND_BEGIN;
    logic       pq = 1'b0;
    logic       pe = 1'b0;

    token_t     expected_tokens[$];
    token_t     oldest_token;
    logic [7:0] tag_bytes[$];
    logic [7:0] dir_bytes[$];
    bit         dir_typed[$];
    token_t     dir_tokens[$];

    int mismatches   = 0;
    int live_bytes   = 0;
    int stall_cycles = 0;
    int tx_idle_pct  = 23;
    int rx_idle_pct  = 72;

    function automatic bit is_name(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
               (b >= "0" && b <= "9") || b == CH_USCORE;
    endfunction

    function automatic bit is_blank(input logic [7:0] b);
        return b == CH_SPACE || b == CH_NL;
    endfunction

    function automatic logic [7:0] rand_name_char();
        int r;
        r = $urandom_range(0, 62);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        if (r < 62) return 8'("0" + r - 52);
        return CH_USCORE;
    endfunction

    function automatic logic [7:0] rand_blank();
        return $urandom_range(0, 1) ? CH_SPACE : CH_NL;
    endfunction

    task automatic skip_step(input logic [7:0] b);
        if (pq) begin
            if (pe) pe = 1'b0;
            else if (b == CH_BSLASH) pe = 1'b1;
            else if (b == CH_QUOTE) pq = 1'b0;
            pm = MODE_SKIP;
        end else if (b == CH_GT) begin
            pm = MODE_SEEK;
            pk = KIND_BEGIN;
        end else begin
            if (b == CH_QUOTE) pq = 1'b1;
            pm = MODE_SKIP;
        end
    endtask

    task automatic raise_error(input logic [2:0] code, input logic [7:0] b, inout token_t t);
        pq = 1'b0;
        pe = 1'b0;
        skip_step(b);
        t.error_code = code;
    endtask

    task automatic tokenise_byte(input logic [7:0] b, output token_t t);
        logic slash;
        logic close;
        t = '0;
        slash = 1'b0;
        close = 1'b0;
        case (pm)
            MODE_LT, MODE_TFIRST: begin
                if (pm == MODE_LT && b == CH_SLASH) begin
                    pk = KIND_END;
                    pm = MODE_TFIRST;
                end else if (is_name(b)) begin
                    t.char_class = CLASS_TITLE;
                    t.char_out = b;
                    pm = MODE_TITLE;
                end else begin
                    raise_error(ERR_NO_TITLE, b, t);
                end
            end
            MODE_TITLE: begin
                if (is_name(b)) begin
                    t.char_class = CLASS_TITLE;
                    t.char_out = b;
                end else if (is_blank(b)) pm = MODE_GAP;
                else if (b == CH_SLASH) slash = 1'b1;
                else if (b == CH_GT) close = 1'b1;
                else raise_error(ERR_NO_CLOSE, b, t);
            end
            MODE_GAP: begin
                if (is_blank(b)) begin
                end else if (is_name(b)) begin
                    t.char_class = CLASS_ANAME;
                    t.char_out = b;
                    pm = MODE_ANAME;
                end else if (b == CH_SLASH) slash = 1'b1;
                else if (b == CH_GT) close = 1'b1;
                else raise_error(ERR_NO_CLOSE, b, t);
            end
            MODE_ANAME: begin
                if (is_name(b)) begin
                    t.char_class = CLASS_ANAME;
                    t.char_out = b;
                end else if (is_blank(b)) begin
                    t.attr_done = 1'b1;
                    pm = MODE_GAP;
                end else if (b == CH_SLASH) begin
                    t.attr_done = 1'b1;
                    slash = 1'b1;
                end else if (b == CH_GT) begin
                    t.attr_done = 1'b1;
                    close = 1'b1;
                end else if (b == CH_EQ) pm = MODE_EQ;
                else raise_error(ERR_NO_EQ, b, t);
            end
            MODE_EQ: begin
                if (b == CH_QUOTE) begin
                    pm = MODE_VALUE;
                    pe = 1'b0;
                end else begin
                    raise_error(ERR_NO_QUOTE, b, t);
                end
            end
            MODE_VALUE: begin
                if (pe) begin
                    pe = 1'b0;
                    t.char_class = CLASS_VALUE;
                    t.char_out = b;
                end else if (b == CH_BSLASH) pe = 1'b1;
                else if (b == CH_QUOTE) begin
                    t.attr_done = 1'b1;
                    t.attr_has_value = 1'b1;
                    pm = MODE_GAP;
                end else begin
                    t.char_class = CLASS_VALUE;
                    t.char_out = b;
                end
            end
            MODE_SLASH: begin
                if (b == CH_GT) close = 1'b1;
                else raise_error(ERR_NO_CLOSE, b, t);
            end
            MODE_SKIP: skip_step(b);
            default: begin
                if (b == CH_LT) begin
                    pm = MODE_LT;
                    pk = KIND_BEGIN;
                    pq = 1'b0;
                    pe = 1'b0;
                end else begin
                    pm = MODE_SEEK;
                end
            end
        endcase
        if (slash) begin
            if (pk == KIND_END) begin
                raise_error(ERR_DSLASH, b, t);
            end else begin
                pk = KIND_SINGLE;
                pm = MODE_SLASH;
            end
        end
        if (close) begin
            t.tag_done = 1'b1;
            t.tag_kind = pk;
            pm = MODE_SEEK;
            pk = KIND_BEGIN;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t: %s got %0h expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic add_row(input logic [7:0] b, input bit typed, input logic [1:0] cls,
                           input logic [7:0] ch, input logic [2:0] err);
        token_t t;
        t = '0;
        t.char_class = cls;
        t.char_out = ch;
        t.error_code = err;
        dir_bytes.push_back(b);
        dir_typed.push_back(typed);
        dir_tokens.push_back(t);
    endtask

    task automatic send_request(input logic [7:0] b, input bit typed, input token_t typed_tok);
        token_t t;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (pm != MODE_SEEK || b == CH_LT) live_bytes++;
        tokenise_byte(b, t);
        expected_tokens.push_back(typed ? typed_tok : t);
    endtask

    task automatic build_tag();
        int         n_attr;
        int         n;
        int         i;
        int         j;
        bit         end_tag;
        logic [7:0] c;
        end_tag = ($urandom_range(0, 3) == 0);
        tag_bytes.push_back(CH_LT);
        if (end_tag) tag_bytes.push_back(CH_SLASH);
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) tag_bytes.push_back(rand_name_char());
        n_attr = end_tag ? (($urandom_range(0, 4) == 0) ? 1 : 0) : $urandom_range(0, 3);
        for (i = 0; i < n_attr; i++) begin
            n = $urandom_range(1, 2);
            for (j = 0; j < n; j++) tag_bytes.push_back(rand_blank());
            n = $urandom_range(1, 5);
            for (j = 0; j < n; j++) tag_bytes.push_back(rand_name_char());
            if ($urandom_range(0, 9) < 6) begin
                tag_bytes.push_back(CH_EQ);
                tag_bytes.push_back(CH_QUOTE);
                n = $urandom_range(0, 6);
                for (j = 0; j < n; j++) begin
                    if ($urandom_range(0, 5) == 0) begin
                        tag_bytes.push_back(CH_BSLASH);
                        tag_bytes.push_back(8'($urandom_range(0, 255)));
                    end else begin
                        c = 8'($urandom_range(0, 255));
                        while (c == CH_QUOTE || c == CH_BSLASH) c = 8'($urandom_range(0, 255));
                        tag_bytes.push_back(c);
                    end
                end
                tag_bytes.push_back(CH_QUOTE);
            end
        end
        if ($urandom_range(0, 3) == 0) tag_bytes.push_back(rand_blank());
        if ((!end_tag && $urandom_range(0, 9) < 3) || (end_tag && $urandom_range(0, 9) == 0))
            tag_bytes.push_back(CH_SLASH);
        tag_bytes.push_back(CH_GT);
    endtask

    task automatic mutate_tag();
        int         pos;
        logic [7:0] c;
        pos = $urandom_range(1, tag_bytes.size() - 1);
        case ($urandom_range(0, 7))
            0: c = CH_QUOTE;
            1: c = CH_LT;
            2: c = CH_EQ;
            3: c = CH_SLASH;
            4: c = CH_GT;
            5: c = CH_BSLASH;
            default: c = 8'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 2))
            0: tag_bytes[pos] = c;
            1: tag_bytes.insert(pos, c);
            default: tag_bytes.delete(pos);
        endcase
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_tokens.size() == 0) begin
                report_mismatch("result with nothing pending", m_tdata[7:0], 8'h00);
            end else begin
                oldest_token = expected_tokens.pop_front();
                if (m_tuser !== oldest_token.char_class)
                    report_mismatch("char_class", 8'(m_tuser), 8'(oldest_token.char_class));
                if (m_tdata[7:0] !== oldest_token.char_out)
                    report_mismatch("char_out", m_tdata[7:0], oldest_token.char_out);
                if (m_tdata[8] !== oldest_token.attr_done)
                    report_mismatch("attr_done", 8'(m_tdata[8]), 8'(oldest_token.attr_done));
                if (m_tdata[9] !== oldest_token.attr_has_value)
                    report_mismatch("attr_has_value", 8'(m_tdata[9]),
                                    8'(oldest_token.attr_has_value));
                if (m_tdata[10] !== oldest_token.tag_done)
                    report_mismatch("tag_done", 8'(m_tdata[10]), 8'(oldest_token.tag_done));
                if (m_tdata[12:11] !== oldest_token.tag_kind)
                    report_mismatch("tag_kind", 8'(m_tdata[12:11]), 8'(oldest_token.tag_kind));
                if (m_tdata[15:13] !== oldest_token.error_code)
                    report_mismatch("error_code", 8'(m_tdata[15:13]),
                                    8'(oldest_token.error_code));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        int   phase;
        int   target;
        int   sel;
        int   k;
        int   n;
        add_row(8'h00,     1'b1, CLASS_NONE,  8'h00, ERR_NONE);
        add_row(8'hFF,     1'b1, CLASS_NONE,  8'h00, ERR_NONE);
        add_row(CH_LT,     1'b1, CLASS_NONE,  8'h00, ERR_NONE);
        add_row(CH_SLASH,  1'b1, CLASS_NONE,  8'h00, ERR_NONE);
        add_row("A",       1'b1, CLASS_TITLE, "A",   ERR_NONE);
        add_row(CH_SLASH,  1'b1, CLASS_NONE,  8'h00, ERR_DSLASH);
        add_row(CH_GT,     1'b1, CLASS_NONE,  8'h00, ERR_NONE);
        add_row(CH_LT,     1'b0, CLASS_NONE,  8'h00, ERR_NONE);
        add_row(CH_GT,     1'b1, CLASS_NONE,  8'h00, ERR_NO_TITLE);
        add_row(CH_LT,     1'b0, CLASS_NONE,  8'h00, ERR_NONE);
        add_row("z",       1'b0, CLASS_NONE,  8'h00, ERR_NONE);
        add_row(CH_NL,     1'b0, CLASS_NONE,  8'h00, ERR_NONE);
        add_row(CH_USCORE, 1'b0, CLASS_NONE,  8'h00, ERR_NONE);
        add_row(CH_EQ,     1'b0, CLASS_NONE,  8'h00, ERR_NONE);
        add_row(CH_QUOTE,  1'b0, CLASS_NONE,  8'h00, ERR_NONE);
        add_row(CH_BSLASH, 1'b0, CLASS_NONE,  8'h00, ERR_NONE);
        add_row(CH_QUOTE,  1'b0, CLASS_NONE,  8'h00, ERR_NONE);
        add_row(CH_QUOTE,  1'b0, CLASS_NONE,  8'h00, ERR_NONE);
        add_row("k",       1'b0, CLASS_NONE,  8'h00, ERR_NONE);
        add_row(CH_SLASH,  1'b0, CLASS_NONE,  8'h00, ERR_NONE);
        add_row(CH_GT,     1'b0, CLASS_NONE,  8'h00, ERR_NONE);
        add_row(CH_LT,     1'b0, CLASS_NONE,  8'h00, ERR_NONE);
        add_row("Q",       1'b0, CLASS_NONE,  8'h00, ERR_NONE);
        add_row(CH_SPACE,  1'b0, CLASS_NONE,  8'h00, ERR_NONE);
        add_row("b",       1'b0, CLASS_NONE,  8'h00, ERR_NONE);
        add_row("#",       1'b1, CLASS_NONE,  8'h00, ERR_NO_EQ);
        add_row(CH_QUOTE,  1'b0, CLASS_NONE,  8'h00, ERR_NONE);
        add_row(CH_GT,     1'b0, CLASS_NONE,  8'h00, ERR_NONE);
        add_row(CH_QUOTE,  1'b0, CLASS_NONE,  8'h00, ERR_NONE);
        add_row(CH_GT,     1'b0, CLASS_NONE,  8'h00, ERR_NONE);
        add_row(CH_LT,     1'b0, CLASS_NONE,  8'h00, ERR_NONE);
        add_row("9",       1'b0, CLASS_NONE,  8'h00, ERR_NONE);
        add_row("!",       1'b1, CLASS_NONE,  8'h00, ERR_NO_CLOSE);
        add_row(CH_GT,     1'b0, CLASS_NONE,  8'h00, ERR_NONE);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (k = 0; k < dir_bytes.size(); k++)
            send_request(dir_bytes[k], dir_typed[k], dir_tokens[k]);
        live_bytes = 0;

        for (phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 72 : 0;
            rx_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 23 : 0;
            target = 550 * (phase + 1);
            while (live_bytes < target) begin
                tag_bytes.delete();
                sel = $urandom_range(0, 99);
                if (sel < 15) begin
                    n = $urandom_range(1, 4);
                    for (k = 0; k < n; k++) tag_bytes.push_back(8'($urandom_range(0, 255)));
                end else begin
                    if ($urandom_range(0, 1) == 0) tag_bytes.push_back(rand_name_char());
                    build_tag();
                    if (sel >= 85) mutate_tag();
                end
                foreach (tag_bytes[k]) send_request(tag_bytes[k], 1'b0, '0);
            end
            // hold off until the pipeline drains
            s_tvalid <= 1'b0;
            while (expected_tokens.size() != 0) @(posedge aclk);
        end

        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/xtt_pkg.sv
rtl/xtt_step.sv
rtl/xml_tag_tokenizer.sv
dv/tb.sv
